FILE: hw/rtl/hkrb_pkg.sv
// Package: request and report types and codes for the HID keyboard report builder.
`timescale 1ns / 1ps

package hkrb_pkg;

    // Slots carried in a boot keyboard report.
    localparam int OUT_SLOTS = 6;

    // Mapped action of a key.
    localparam logic [1:0] ACT_OTHER = 2'd0;
    localparam logic [1:0] ACT_KEY   = 2'd1;
    localparam logic [1:0] ACT_MEDIA = 2'd2;

    // Report kinds.
    localparam logic [1:0] REP_KBD           = 2'd0;
    localparam logic [1:0] REP_MEDIA_PRESS   = 2'd1;
    localparam logic [1:0] REP_MEDIA_RELEASE = 2'd2;

    typedef struct packed {
        logic        key_pressed;
        logic        key_changed;
        logic [1:0]  action_kind;
        logic [7:0]  modifier_bits;
        logic [7:0]  key_code;
        logic [15:0] media_usage;
        logic        scan_end;
        logic        kbd_link_ready;
        logic        media_link_ready;
    } key_item_t;

    typedef struct packed {
        logic [1:0]  report_kind;
        logic [7:0]  report_modifiers;
        logic [7:0]  slot0_code;
        logic [7:0]  slot1_code;
        logic [7:0]  slot2_code;
        logic [7:0]  slot3_code;
        logic [7:0]  slot4_code;
        logic [7:0]  slot5_code;
        logic [15:0] report_usage;
        logic        report_last;
    } report_t;

endpackage

FILE: hw/rtl/hid_keyboard_report_builder.sv
// Top level: HID boot keyboard (6KRO) and consumer report builder.
`timescale 1ns / 1ps

// Takes one key request per cycle, in scan order, and accumulates the scan in
// registers: ORed modifiers, up to KEY_SLOTS keycodes in key order (extra
// codes dropped) and the usage of the first pressed media key. Each key is
// folded into the scan state in the cycle it is accepted, so the key stream
// runs at one request per clock while s_ready is high. On the last key of a scan
// (scan_end, or the NUM_KEYS-th key) up to two reports are written into a
// four-entry result queue in that same cycle: a keyboard report, then a media
// press or release, each only if pending or changed in the scan and its link
// flag is set. Reports leave the queue at one per cycle while m_ready is high;
// s_ready drops while the queue holds more than two reports, which happens when
// the result side stalls or when short scans that each end in two reports
// follow one another closely. With an empty queue a report is presented from
// the edge that accepts its key and can be taken at the next edge. Keyboard
// slots beyond six are kept but not reported; with KEY_SLOTS below six the
// upper report slots read zero.

module hid_keyboard_report_builder #(
    parameter int KEY_SLOTS = 6,
    parameter int NUM_KEYS  = 16
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  hkrb_pkg::key_item_t s_data,

    output logic                m_valid,
    input  logic                m_ready,
    output hkrb_pkg::report_t   m_data
);

    localparam int SU_W   = $clog2(KEY_SLOTS + 1);
    localparam int IDX_W  = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;
    localparam int KC_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int Q_DEPTH = 4;
    localparam int QP_W   = 2;
    localparam int QC_W   = 3;

    // ---------------------------------------------------------------
    // Scan state
    // ---------------------------------------------------------------
    logic              kbd_pending_reg,  kbd_pending_next;
    logic              media_pending_reg, media_pending_next;
    logic              change_seen_reg,  change_seen_next;
    logic [7:0]        mod_accum_reg,    mod_accum_next;
    logic [7:0]        code_slots_reg  [KEY_SLOTS];
    logic [7:0]        code_slots_next [KEY_SLOTS];
    logic [SU_W-1:0]   slots_used_reg,   slots_used_next;
    logic              media_found_reg,  media_found_next;
    logic [15:0]       media_code_reg,   media_code_next;
    logic [KC_W-1:0]   key_count_reg,    key_count_next;

    // Result queue
    hkrb_pkg::report_t q_mem_reg [Q_DEPTH];
    logic [QP_W-1:0]   q_rd_reg, q_rd_next;
    logic [QP_W-1:0]   q_wr_reg, q_wr_next;
    logic [QC_W-1:0]   q_cnt_reg, q_cnt_next;

    logic              s_fire, m_fire;
    logic              last_key;
    logic              change_any;
    logic              kbd_take, code_take, media_take;
    logic [SU_W-1:0]   slots_used_c;
    logic [7:0]        mod_c;
    logic [15:0]       media_code_c;
    logic              kbd_due, media_due;
    logic              emit_kbd, emit_media;
    logic [7:0]        rep_slot [hkrb_pkg::OUT_SLOTS];
    hkrb_pkg::report_t kbd_rep, media_rep, rep0, rep1;
    logic [1:0]        n_push;

    assign s_ready = (q_cnt_reg <= QC_W'(Q_DEPTH - 2));
    assign s_fire  = s_valid && s_ready;
    assign m_valid = (q_cnt_reg != '0);
    assign m_fire  = m_valid && m_ready;
    assign m_data  = q_mem_reg[q_rd_reg];

    assign last_key   = s_data.scan_end || (key_count_reg == KC_W'(NUM_KEYS - 1));
    assign change_any = change_seen_reg || s_data.key_changed;

    assign kbd_take   = s_data.key_pressed && (s_data.action_kind == hkrb_pkg::ACT_KEY);
    assign code_take  = kbd_take && (s_data.key_code != 8'd0)
                        && (slots_used_reg < SU_W'(KEY_SLOTS));
    assign media_take = s_data.key_pressed && (s_data.action_kind == hkrb_pkg::ACT_MEDIA)
                        && !media_found_reg;

    // Scan values including the current key
    assign mod_c        = kbd_take ? (mod_accum_reg | s_data.modifier_bits) : mod_accum_reg;
    assign slots_used_c = code_take ? (slots_used_reg + SU_W'(1)) : slots_used_reg;
    assign media_code_c = media_take ? s_data.media_usage : media_code_reg;

    always_comb begin
        for (int i = 0; i < KEY_SLOTS; i++) begin
            code_slots_next[i] = code_slots_reg[i];
        end
        if (code_take) begin
            code_slots_next[slots_used_reg[IDX_W-1:0]] = s_data.key_code;
        end
    end

    // Slots past the fill level read as empty, so the store needs no clear.
    genvar g;
    generate
        for (g = 0; g < hkrb_pkg::OUT_SLOTS; g++) begin : g_slot
            if (g < KEY_SLOTS) begin : g_live
                assign rep_slot[g] = (SU_W'(g) < slots_used_c) ? code_slots_next[g] : 8'd0;
            end else begin : g_none
                assign rep_slot[g] = 8'd0;
            end
        end
    endgenerate

    assign kbd_due    = kbd_pending_reg || change_any;
    assign media_due  = media_pending_reg || change_any;
    assign emit_kbd   = last_key && kbd_due && s_data.kbd_link_ready;
    assign emit_media = last_key && media_due && s_data.media_link_ready;

    always_comb begin
        kbd_rep                  = '0;
        kbd_rep.report_kind      = hkrb_pkg::REP_KBD;
        kbd_rep.report_modifiers = mod_c;
        kbd_rep.slot0_code       = rep_slot[0];
        kbd_rep.slot1_code       = rep_slot[1];
        kbd_rep.slot2_code       = rep_slot[2];
        kbd_rep.slot3_code       = rep_slot[3];
        kbd_rep.slot4_code       = rep_slot[4];
        kbd_rep.slot5_code       = rep_slot[5];
        kbd_rep.report_last      = !emit_media;

        media_rep             = '0;
        media_rep.report_last = 1'b1;
        if (media_code_c != 16'd0) begin
            media_rep.report_kind  = hkrb_pkg::REP_MEDIA_PRESS;
            media_rep.report_usage = media_code_c;
        end else begin
            media_rep.report_kind  = hkrb_pkg::REP_MEDIA_RELEASE;
        end

        rep0   = emit_kbd ? kbd_rep : media_rep;
        rep1   = media_rep;
        n_push = 2'(emit_kbd) + 2'(emit_media);
    end

    // Next scan state
    always_comb begin
        kbd_pending_next   = kbd_pending_reg;
        media_pending_next = media_pending_reg;
        change_seen_next   = change_seen_reg;
        mod_accum_next     = mod_accum_reg;
        slots_used_next    = slots_used_reg;
        media_found_next   = media_found_reg;
        media_code_next    = media_code_reg;
        key_count_next     = key_count_reg;
        if (s_fire) begin
            if (last_key) begin
                kbd_pending_next   = kbd_due && !s_data.kbd_link_ready;
                media_pending_next = media_due && !s_data.media_link_ready;
                change_seen_next   = 1'b0;
                mod_accum_next     = '0;
                slots_used_next    = '0;
                media_found_next   = 1'b0;
                media_code_next    = '0;
                key_count_next     = '0;
            end else begin
                change_seen_next   = change_any;
                mod_accum_next     = mod_c;
                slots_used_next    = slots_used_c;
                media_found_next   = media_found_reg || media_take;
                media_code_next    = media_code_c;
                key_count_next     = key_count_reg + KC_W'(1);
            end
        end
    end

    // Queue pointers
    always_comb begin
        q_rd_next  = m_fire ? (q_rd_reg + QP_W'(1)) : q_rd_reg;
        q_wr_next  = q_wr_reg;
        q_cnt_next = q_cnt_reg - QC_W'(m_fire);
        if (s_fire) begin
            q_wr_next  = q_wr_reg + QP_W'(n_push);
            q_cnt_next = q_cnt_reg - QC_W'(m_fire) + QC_W'(n_push);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kbd_pending_reg   <= 1'b1;
            media_pending_reg <= 1'b0;
            change_seen_reg   <= 1'b0;
            mod_accum_reg     <= '0;
            slots_used_reg    <= '0;
            media_found_reg   <= 1'b0;
            media_code_reg    <= '0;
            key_count_reg     <= '0;
            q_rd_reg          <= '0;
            q_wr_reg          <= '0;
            q_cnt_reg         <= '0;
        end else begin
            kbd_pending_reg   <= kbd_pending_next;
            media_pending_reg <= media_pending_next;
            change_seen_reg   <= change_seen_next;
            mod_accum_reg     <= mod_accum_next;
            slots_used_reg    <= slots_used_next;
            media_found_reg   <= media_found_next;
            media_code_reg    <= media_code_next;
            key_count_reg     <= key_count_next;
            q_rd_reg          <= q_rd_next;
            q_wr_reg          <= q_wr_next;
            q_cnt_reg         <= q_cnt_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int i = 0; i < KEY_SLOTS; i++) begin
                code_slots_reg[i] <= code_slots_next[i];
            end
            if (n_push != 2'd0) begin
                q_mem_reg[q_wr_reg] <= rep0;
            end
            if (n_push == 2'd2) begin
                q_mem_reg[q_wr_reg + QP_W'(1)] <= rep1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Queue never overfills.
    a_q_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        q_cnt_reg <= QC_W'(Q_DEPTH))
        else $error("result queue overflow");

    // A key that does not end the scan adds no report.
    a_mid_scan_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && !last_key) |=> (q_cnt_reg <= $past(q_cnt_reg)))
        else $error("report queued mid-scan");

    // Scan end clears the accumulated scan.
    a_scan_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && last_key) |=> (key_count_reg == '0 && slots_used_reg == '0
                                  && !change_seen_reg && !media_found_reg))
        else $error("scan state not cleared");

    // Fill level stays within the slot store.
    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        slots_used_reg <= SU_W'(KEY_SLOTS))
        else $error("slot fill level out of range");
`endif

endmodule
